FILE: src/dpwbe_pkg.sv
// Shared constants, tables and types for the DCT pair watermark bit extractor.
// Holds the cosine and zigzag tables and the basis ROM entry function.
// No dependencies.
package dpwbe_pkg;

   localparam int BLOCK_SIDE         = 8;
   localparam int BLOCK_PIXELS       = BLOCK_SIDE * BLOCK_SIDE;
   localparam int COUNT_BITS         = $clog2(BLOCK_PIXELS);
   localparam int PIXEL_BITS         = 8;
   localparam int PAIR_BITS          = 5;
   localparam int MAX_PAIR           = 28;
   localparam int LEVEL_SHIFT        = 128;
   localparam int FIRST_POS          = 6;
   localparam int SECOND_POS         = 7;
   localparam int SHIFTED_BITS       = PIXEL_BITS + 1;
   localparam int ACC_BITS           = 32;
   localparam int BASIS_BITS_DEFAULT = 16;

   // cos(m*pi/16) for m = 0..8 in Q2.30.
   localparam longint COS_Q30 [9] = '{
      64'd1073741824, 64'd1053110176, 64'd992008094, 64'd892783698, 64'd759250125,
      64'd596538995, 64'd410903207, 64'd209476638, 64'd0
   };

   // Zigzag position to raster index (row*8+col).
   localparam int ZZ_ORDER [BLOCK_PIXELS] = '{
       0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
      12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
      35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
      58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
   };

   // Pipeline tag that travels with one pixel word.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } ctrl_type;

   // One-dimensional factor in Q2.30. Frequency zero uses sqrt(1/2), so that
   // the 2-D product scaled down by four is orthonormal.
   function automatic longint axis_factor(int freq, int pos);
      int m;
      if (freq == 0) begin
         return COS_Q30[4];
      end
      m = ((2 * pos + 1) * freq) & 31;
      if (m > 16) begin
         m = 32 - m;
      end
      if (m > 8) begin
         return -COS_Q30[16 - m];
      end
      return COS_Q30[m];
   endfunction

   // Basis entry for the coefficient at raster index coef and the pixel at
   // raster index n, rounded half away from zero to bits-2 fraction bits.
   function automatic longint basis_entry(int coef, int n, int bits);
      int     u;
      int     v;
      int     y;
      int     x;
      int     sh;
      longint prod;
      longint mag;
      longint r;
      u    = (coef / BLOCK_SIDE) % BLOCK_SIDE;
      v    = coef % BLOCK_SIDE;
      y    = (n / BLOCK_SIDE) % BLOCK_SIDE;
      x    = n % BLOCK_SIDE;
      prod = axis_factor(u, y) * axis_factor(v, x);
      sh   = 64 - bits;
      mag  = (prod < 0) ? -prod : prod;
      r    = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return (prod < 0) ? -r : r;
   endfunction

endpackage

FILE: src/dpwbe_basis_rom.sv
// Basis product ROM: one word per (pair index, pixel index) holding the
// basis entries of both coefficients of the pair. Registered read.
// Depends on dpwbe_pkg.
module dpwbe_basis_rom #(
   parameter int BASIS_BITS = dpwbe_pkg::BASIS_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  rd_en,
   input  logic [dpwbe_pkg::PAIR_BITS+dpwbe_pkg::COUNT_BITS-1:0] rd_addr,
   output logic [2*BASIS_BITS-1:0]                               rd_data
);

   localparam int WordBits = 2 * BASIS_BITS;
   localparam int RomDepth = (1 << dpwbe_pkg::PAIR_BITS) * dpwbe_pkg::BLOCK_PIXELS;

   typedef logic [WordBits-1:0] rom_type [RomDepth];

   function automatic rom_type build_rom();
      rom_type r;
      int      k;
      int      n;
      int      p1;
      int      p2;
      longint  e1;
      longint  e2;
      for (int i = 0; i < RomDepth; i++) begin
         k  = i / dpwbe_pkg::BLOCK_PIXELS;
         n  = i % dpwbe_pkg::BLOCK_PIXELS;
         if (k > dpwbe_pkg::MAX_PAIR) begin
            k = dpwbe_pkg::MAX_PAIR;
         end
         p1   = (dpwbe_pkg::FIRST_POS + 2 * k) % dpwbe_pkg::BLOCK_PIXELS;
         p2   = (dpwbe_pkg::SECOND_POS + 2 * k) % dpwbe_pkg::BLOCK_PIXELS;
         e1   = dpwbe_pkg::basis_entry(dpwbe_pkg::ZZ_ORDER[p1], n, BASIS_BITS);
         e2   = dpwbe_pkg::basis_entry(dpwbe_pkg::ZZ_ORDER[p2], n, BASIS_BITS);
         r[i] = {e1[BASIS_BITS-1:0], e2[BASIS_BITS-1:0]};
      end
      return r;
   endfunction

   localparam rom_type RomData = build_rom();

   logic [WordBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= RomData[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/dpwbe_accum.sv
// Multiply-accumulate stage: scales each level-shifted pixel by the two
// basis entries and sums into the two coefficient accumulators.
// Depends on dpwbe_pkg.
module dpwbe_accum #(
   parameter int BASIS_BITS = dpwbe_pkg::BASIS_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  dpwbe_pkg::ctrl_type                        ctrl,
   input  logic signed [dpwbe_pkg::SHIFTED_BITS-1:0]  pixel_shifted,
   input  logic signed [BASIS_BITS-1:0]               basis_first,
   input  logic signed [BASIS_BITS-1:0]               basis_second,
   output logic signed [dpwbe_pkg::ACC_BITS-1:0]      acc_first,
   output logic signed [dpwbe_pkg::ACC_BITS-1:0]      acc_second,
   output logic                                       done
);

   localparam int AccBits  = dpwbe_pkg::ACC_BITS;
   localparam int ProdBits = dpwbe_pkg::SHIFTED_BITS + BASIS_BITS;

   logic signed [ProdBits-1:0] prod_first;
   logic signed [ProdBits-1:0] prod_second;
   logic signed [AccBits-1:0]  term_first;
   logic signed [AccBits-1:0]  term_second;
   logic signed [AccBits-1:0]  acc_first_ff;
   logic signed [AccBits-1:0]  acc_first_in;
   logic signed [AccBits-1:0]  acc_second_ff;
   logic signed [AccBits-1:0]  acc_second_in;
   logic                       done_ff;
   logic                       done_in;

   // Products wrap modulo 2^32 exactly like the sums, so a plain resize works
   // whether the product is narrower or wider than the accumulator.
   always_comb begin
      prod_first  = ProdBits'(pixel_shifted) * ProdBits'(basis_first);
      prod_second = ProdBits'(pixel_shifted) * ProdBits'(basis_second);
      term_first  = AccBits'(prod_first);
      term_second = AccBits'(prod_second);
      acc_first_in  = acc_first_ff;
      acc_second_in = acc_second_ff;
      if (ctrl.valid) begin
         acc_first_in  = ctrl.first ? term_first  : acc_first_ff  + term_first;
         acc_second_in = ctrl.first ? term_second : acc_second_ff + term_second;
      end
      done_in = ctrl.valid && ctrl.last;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_first_ff  <= acc_first_in;
         acc_second_ff <= acc_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (advance) begin
         done_ff <= done_in;
      end
   end

   assign acc_first  = acc_first_ff;
   assign acc_second = acc_second_ff;
   assign done       = done_ff;

`ifndef SYNTH
   // A held stage must not lose its block result.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_ff && !advance |=> done_ff)
      else $error("done flag dropped while stalled");

   // The first pixel of a block restarts both sums from its own products.
   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && ctrl.valid && ctrl.first |=>
         acc_first_ff == $past(term_first) && acc_second_ff == $past(term_second))
      else $error("accumulators not restarted on first pixel");

   // A pixel word is never both the first and the last of a block.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.valid |-> !(ctrl.first && ctrl.last))
      else $error("pixel tagged both first and last");
`endif

endmodule

FILE: src/dct_pair_watermark_bit_extract_top.sv
// Top level of the DCT pair watermark bit extractor: pixel counter and pair
// register, basis ROM read stage, accumulators and the result register.
// Depends on dpwbe_pkg, dpwbe_basis_rom and dpwbe_accum.
//
//   channel  direction  ports                                   words
//   req      in         req_valid/ready, req_pixel, req_pair_index  one pixel
//   rsp      out        rsp_valid/ready, rsp_bit_res              one bit per block
//
// One pixel word is taken per cycle while req_ready is high. After the 64th
// pixel of a block is accepted, its result passes through the registered ROM
// read, then the accumulators, then the compare into the result register.
// The basis ROM read port and the two multiply-accumulate units set the
// one-pixel-per-cycle rate. Reset is synchronous and clears the pixel counter
// and all valid flags. req_ready drops only while a finished block result
// waits to enter the result register and that register is still held.
module dct_pair_watermark_bit_extract_top #(
   parameter int BASIS_BITS = dpwbe_pkg::BASIS_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dpwbe_pkg::PIXEL_BITS-1:0]    req_pixel,
   input  logic [dpwbe_pkg::PAIR_BITS-1:0]     req_pair_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_bit_res
);

   localparam int CountBits   = dpwbe_pkg::COUNT_BITS;
   localparam int PairBits    = dpwbe_pkg::PAIR_BITS;
   localparam int ShiftedBits = dpwbe_pkg::SHIFTED_BITS;
   localparam int AccBits     = dpwbe_pkg::ACC_BITS;

   logic                           accept;
   logic                           advance;
   logic                           stall;
   logic                           is_first;
   logic                           is_last;
   logic [PairBits-1:0]            pair_sat;
   logic [PairBits-1:0]            pair_cur;
   logic [CountBits-1:0]           count_ff;
   logic [CountBits-1:0]           count_in;
   logic [PairBits-1:0]            held_ff;
   logic [PairBits-1:0]            held_in;
   dpwbe_pkg::ctrl_type            ctrl1_ff;
   dpwbe_pkg::ctrl_type            ctrl1_in;
   logic signed [ShiftedBits-1:0]  pix1_ff;
   logic signed [ShiftedBits-1:0]  pix1_in;
   logic [2*BASIS_BITS-1:0]        basis_word;
   logic signed [AccBits-1:0]      acc_first;
   logic signed [AccBits-1:0]      acc_second;
   logic                           done;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_bit_ff;
   logic                           rsp_bit_in;

   // The whole pipeline holds only when a block result cannot enter the
   // result register.
   assign stall     = done && rsp_valid_ff && !rsp_ready;
   assign advance   = !stall;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_first = (count_ff == '0);
      is_last  = (count_ff == CountBits'(dpwbe_pkg::BLOCK_PIXELS - 1));
      pair_sat = (req_pair_index > PairBits'(dpwbe_pkg::MAX_PAIR)) ?
                 PairBits'(dpwbe_pkg::MAX_PAIR) : req_pair_index;
      pair_cur = is_first ? pair_sat : held_ff;
      count_in = accept ? count_ff + CountBits'(1) : count_ff;
      held_in  = (accept && is_first) ? pair_sat : held_ff;
      ctrl1_in.valid = accept;
      ctrl1_in.first = is_first;
      ctrl1_in.last  = is_last;
      pix1_in  = $signed({1'b0, req_pixel} - ShiftedBits'(dpwbe_pkg::LEVEL_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
         ctrl1_ff <= '0;
      end else begin
         count_ff <= count_in;
         held_ff  <= held_in;
         if (advance) begin
            ctrl1_ff <= ctrl1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix1_ff <= pix1_in;
      end
   end

   dpwbe_basis_rom #(
      .BASIS_BITS (BASIS_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (advance),
      .rd_addr ({pair_cur, count_ff}),
      .rd_data (basis_word)
   );

   dpwbe_accum #(
      .BASIS_BITS (BASIS_BITS)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctrl          (ctrl1_ff),
      .pixel_shifted (pix1_ff),
      .basis_first   ($signed(basis_word[2*BASIS_BITS-1:BASIS_BITS])),
      .basis_second  ($signed(basis_word[BASIS_BITS-1:0])),
      .acc_first     (acc_first),
      .acc_second    (acc_second),
      .done          (done)
   );

   // The compare reads the finished sums before the next block overwrites them.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in   = rsp_bit_ff;
      if (done && advance) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = (acc_first < acc_second);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bit_res = rsp_bit_ff;

`ifndef SYNTH
   // The 64th pixel of a block is tagged last in the ROM read stage.
   a_last_tagged: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> ctrl1_ff.valid && ctrl1_ff.last)
      else $error("last pixel not tagged");

   // While stalled the sums of the waiting block stay put.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(acc_first) && $stable(acc_second))
      else $error("accumulators moved during stall");

   // A new result appears only when a block has just finished.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done))
      else $error("result without a finished block");
`endif

endmodule
